@@ hdl/bblur_pkg.sv @@
package bblur_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned COL_SUM_W  = 10;  // three pixels: up to 765
    localparam int unsigned COL_CNT_W  = 2;   // one to three pixels
    localparam int unsigned WIN_SUM_W  = 12;  // nine pixels: up to 2295
    localparam int unsigned WIN_CNT_W  = 4;   // one to nine pixels
    localparam int unsigned NUM_W      = 13;  // 2*sum + count: up to 4599
    localparam int unsigned RECIP_W    = 18;
    localparam int unsigned RECIP_SHIFT = 18;
    localparam int unsigned PROD_W     = NUM_W + RECIP_W;
    localparam int unsigned SEEN_W     = 2;

    typedef struct packed {
        logic [PIX_W-1:0] top_red;
        logic [PIX_W-1:0] top_green;
        logic [PIX_W-1:0] top_blue;
        logic [PIX_W-1:0] mid_red;
        logic [PIX_W-1:0] mid_green;
        logic [PIX_W-1:0] mid_blue;
        logic [PIX_W-1:0] bottom_red;
        logic [PIX_W-1:0] bottom_green;
        logic [PIX_W-1:0] bottom_blue;
        logic             has_top;
        logic             has_bottom;
        logic             last_in_row;
    } col_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic             end_of_row;
    } res_word_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;      // capture the column word
        logic live;      // use the word on the input port, not the captured one
        logic prep;      // form numerators and reciprocal for one result
        logic job_last;  // the result being formed closes the row
        logic fire;      // multiply and load the output register
        logic update;    // shift or clear the held columns
    } ctrl_cmd_t;

    typedef struct packed {
        logic seen_zero;  // no column of this row is held
        logic last_live;  // last_in_row of the word on the input port
        logic last_reg;   // last_in_row of the captured word
        logic out_free;   // output register empty or being taken
    } ctrl_status_t;

    // ceil(2^RECIP_SHIFT / (2*n)); exact floor for numerators below 2^18/18.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [WIN_CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        begin
            case (n)
                4'd1:    r = 18'd131072;
                4'd2:    r = 18'd65536;
                4'd3:    r = 18'd43691;
                4'd4:    r = 18'd32768;
                4'd5:    r = 18'd26215;
                4'd6:    r = 18'd21846;
                4'd7:    r = 18'd18725;
                4'd8:    r = 18'd16384;
                4'd9:    r = 18'd14564;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ hdl/bblur_column_if.sv @@
interface bblur_column_if;
    logic                       valid;
    logic                       ready;
    logic [bblur_pkg::PIX_W-1:0] top_red;
    logic [bblur_pkg::PIX_W-1:0] top_green;
    logic [bblur_pkg::PIX_W-1:0] top_blue;
    logic [bblur_pkg::PIX_W-1:0] mid_red;
    logic [bblur_pkg::PIX_W-1:0] mid_green;
    logic [bblur_pkg::PIX_W-1:0] mid_blue;
    logic [bblur_pkg::PIX_W-1:0] bottom_red;
    logic [bblur_pkg::PIX_W-1:0] bottom_green;
    logic [bblur_pkg::PIX_W-1:0] bottom_blue;
    logic                       has_top;
    logic                       has_bottom;
    logic                       last_in_row;

    modport source (
        output valid, top_red, top_green, top_blue, mid_red, mid_green, mid_blue,
               bottom_red, bottom_green, bottom_blue, has_top, has_bottom, last_in_row,
        input  ready
    );

    modport sink (
        input  valid, top_red, top_green, top_blue, mid_red, mid_green, mid_blue,
               bottom_red, bottom_green, bottom_blue, has_top, has_bottom, last_in_row,
        output ready
    );
endinterface

@@ hdl/bblur_result_if.sv @@
interface bblur_result_if;
    logic                       valid;
    logic                       ready;
    logic [bblur_pkg::PIX_W-1:0] out_red;
    logic [bblur_pkg::PIX_W-1:0] out_green;
    logic [bblur_pkg::PIX_W-1:0] out_blue;
    logic                       end_of_row;

    modport source (
        output valid, out_red, out_green, out_blue, end_of_row,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, end_of_row,
        output ready
    );
endinterface

@@ hdl/box_blur_edge_aware.sv @@
// Edge-aware 3x3 box blur on RGB pixels. Feed one column word per pixel of a
// row, left to right: the pixel itself plus the pixels above and below, with
// has_top/has_bottom marking which of those exist and last_in_row marking the
// rightmost column. Each result is the average of the neighbors that exist,
// rounded half up. A pixel's result leaves when the column to its right has
// been taken, so results trail the input by one column; the rightmost column
// word yields two results (its left neighbor, then itself with end_of_row set),
// or one for a row that is a single pixel wide. The block works on one column
// word at a time: a word that yields no result (the first of a row) is only
// accepted and shifted in. Each result has a prep step, which forms the window
// sum and looks up the reciprocal of twice the pixel count, then a fire step,
// whose three reciprocal multiplies load the output register once it is free;
// the first result of a word is prepared as the word is accepted, and the
// row-closing word of a longer row then adds a prep and fire for itself. A new
// column word is taken while a finished result still waits in the output
// register; a stalled result holds the next one back in the multiply step.
module box_blur_edge_aware (
    input  logic                  clk,
    input  logic                  rst_n,
    bblur_column_if.sink          column,
    bblur_result_if.source        result
);

    bblur_pkg::col_word_t    col_word;
    bblur_pkg::res_word_t    res_word;
    bblur_pkg::ctrl_cmd_t    cmd;
    bblur_pkg::ctrl_status_t status;
    logic                    in_ready;
    logic                    res_valid;

    // pack the column word
    assign col_word.top_red      = column.top_red;
    assign col_word.top_green    = column.top_green;
    assign col_word.top_blue     = column.top_blue;
    assign col_word.mid_red      = column.mid_red;
    assign col_word.mid_green    = column.mid_green;
    assign col_word.mid_blue     = column.mid_blue;
    assign col_word.bottom_red   = column.bottom_red;
    assign col_word.bottom_green = column.bottom_green;
    assign col_word.bottom_blue  = column.bottom_blue;
    assign col_word.has_top      = column.has_top;
    assign col_word.has_bottom   = column.has_bottom;
    assign col_word.last_in_row  = column.last_in_row;
    assign column.ready          = in_ready;

    // sequencer: accept, form each result, retire the column
    bblur_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (column.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // held columns, window sums, reciprocal multiply and output register
    bblur_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .col_word  (col_word),
        .cmd       (cmd),
        .status    (status),
        .res_word  (res_word),
        .res_valid (res_valid),
        .res_ready (result.ready)
    );

    // unpack the result word
    assign result.valid      = res_valid;
    assign result.out_red    = res_word.out_red;
    assign result.out_green  = res_word.out_green;
    assign result.out_blue   = res_word.out_blue;
    assign result.end_of_row = res_word.end_of_row;

endmodule

@@ hdl/bblur_ctrl.sv @@
module bblur_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  bblur_pkg::ctrl_status_t status,
    output bblur_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRE,
        ST_PREP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   job_last_reg;
    logic   job_last_next;

    always_comb
    begin
        state_next    = state_reg;
        job_last_next = job_last_reg;
        cmd           = '0;
        in_ready      = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.live = 1'b1;
                    if (!status.seen_zero)
                    begin
                        // left neighbor now complete: its result goes first
                        cmd.prep      = 1'b1;
                        cmd.job_last  = 1'b0;
                        job_last_next = 1'b0;
                        state_next    = ST_FIRE;
                    end
                    else if (status.last_live)
                    begin
                        cmd.prep      = 1'b1;
                        cmd.job_last  = 1'b1;
                        job_last_next = 1'b1;
                        state_next    = ST_FIRE;
                    end
                    else
                    begin
                        cmd.update = 1'b1;
                    end
                end
            end
            ST_FIRE:
            begin
                if (status.out_free)
                begin
                    cmd.fire = 1'b1;
                    if (!job_last_reg && status.last_reg)
                    begin
                        state_next = ST_PREP;
                    end
                    else
                    begin
                        cmd.update = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep      = 1'b1;
                cmd.job_last  = 1'b1;
                job_last_next = 1'b1;
                state_next    = ST_FIRE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            job_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            job_last_reg <= job_last_next;
        end
    end

endmodule

@@ hdl/bblur_dp.sv @@
module bblur_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bblur_pkg::col_word_t    col_word,
    input  bblur_pkg::ctrl_cmd_t    cmd,
    output bblur_pkg::ctrl_status_t status,
    output bblur_pkg::res_word_t    res_word,
    output logic                    res_valid,
    input  logic                    res_ready
);

    // held columns of the current row: older and newer
    logic [bblur_pkg::COL_SUM_W-1:0] old_sum_reg [3];
    logic [bblur_pkg::COL_SUM_W-1:0] new_sum_reg [3];
    logic [bblur_pkg::COL_CNT_W-1:0] old_cnt_reg;
    logic [bblur_pkg::COL_CNT_W-1:0] new_cnt_reg;
    logic [bblur_pkg::SEEN_W-1:0]    seen_reg;

    // captured column
    logic [bblur_pkg::COL_SUM_W-1:0] cur_sum_reg [3];
    logic [bblur_pkg::COL_CNT_W-1:0] cur_cnt_reg;
    logic                            last_reg;

    // divider operands
    logic [bblur_pkg::NUM_W-1:0]     num_reg [3];
    logic [bblur_pkg::RECIP_W-1:0]   recip_reg;
    logic                            eor_pend_reg;

    // output register
    logic [bblur_pkg::PIX_W-1:0]     quo_reg [3];
    logic                            eor_reg;
    logic                            res_valid_reg;
    logic                            res_valid_next;

    logic [bblur_pkg::PIX_W-1:0]     top_pix [3];
    logic [bblur_pkg::PIX_W-1:0]     mid_pix [3];
    logic [bblur_pkg::PIX_W-1:0]     bot_pix [3];
    logic [bblur_pkg::COL_SUM_W-1:0] live_sum [3];
    logic [bblur_pkg::COL_CNT_W-1:0] live_cnt;
    logic [bblur_pkg::COL_SUM_W-1:0] use_sum [3];
    logic [bblur_pkg::COL_CNT_W-1:0] use_cnt;
    logic                            use_last;
    logic [bblur_pkg::WIN_SUM_W-1:0] win_sum [3];
    logic [bblur_pkg::WIN_CNT_W-1:0] win_cnt;
    logic [bblur_pkg::NUM_W-1:0]     win_num [3];
    logic [bblur_pkg::PROD_W-1:0]    prod [3];
    logic                            add_new;
    logic                            add_old;

    assign top_pix[0] = col_word.top_red;
    assign top_pix[1] = col_word.top_green;
    assign top_pix[2] = col_word.top_blue;
    assign mid_pix[0] = col_word.mid_red;
    assign mid_pix[1] = col_word.mid_green;
    assign mid_pix[2] = col_word.mid_blue;
    assign bot_pix[0] = col_word.bottom_red;
    assign bot_pix[1] = col_word.bottom_green;
    assign bot_pix[2] = col_word.bottom_blue;

    always_comb
    begin
        live_cnt = bblur_pkg::COL_CNT_W'(1)
                 + bblur_pkg::COL_CNT_W'(col_word.has_top)
                 + bblur_pkg::COL_CNT_W'(col_word.has_bottom);
        for (int c = 0; c < 3; c++)
        begin
            live_sum[c] = bblur_pkg::COL_SUM_W'(mid_pix[c])
                        + (col_word.has_top ? bblur_pkg::COL_SUM_W'(top_pix[c]) : '0)
                        + (col_word.has_bottom ? bblur_pkg::COL_SUM_W'(bot_pix[c]) : '0);
            use_sum[c]  = cmd.live ? live_sum[c] : cur_sum_reg[c];
        end
        use_cnt  = cmd.live ? live_cnt : cur_cnt_reg;
        use_last = cmd.live ? col_word.last_in_row : last_reg;
    end

    // window of the result being formed: a row-closing result takes the newer
    // column and this one; otherwise the newer column is the center
    always_comb
    begin
        add_new = cmd.job_last ? (seen_reg != '0) : 1'b1;
        add_old = cmd.job_last ? 1'b0 : seen_reg[1];
        win_cnt = bblur_pkg::WIN_CNT_W'(use_cnt)
                + (add_new ? bblur_pkg::WIN_CNT_W'(new_cnt_reg) : '0)
                + (add_old ? bblur_pkg::WIN_CNT_W'(old_cnt_reg) : '0);
        for (int c = 0; c < 3; c++)
        begin
            win_sum[c] = bblur_pkg::WIN_SUM_W'(use_sum[c])
                       + (add_new ? bblur_pkg::WIN_SUM_W'(new_sum_reg[c]) : '0)
                       + (add_old ? bblur_pkg::WIN_SUM_W'(old_sum_reg[c]) : '0);
            win_num[c] = {win_sum[c], 1'b0} + bblur_pkg::NUM_W'(win_cnt);
            prod[c]    = bblur_pkg::PROD_W'(num_reg[c]) * bblur_pkg::PROD_W'(recip_reg);
        end
    end

    assign res_valid_next = cmd.fire ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                old_sum_reg[c] <= '0;
                new_sum_reg[c] <= '0;
            end
            old_cnt_reg   <= '0;
            new_cnt_reg   <= '0;
            seen_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cmd.update)
            begin
                if (use_last)
                begin
                    // row done: drop the held columns
                    for (int c = 0; c < 3; c++)
                    begin
                        old_sum_reg[c] <= '0;
                        new_sum_reg[c] <= '0;
                    end
                    old_cnt_reg <= '0;
                    new_cnt_reg <= '0;
                    seen_reg    <= '0;
                end
                else
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        old_sum_reg[c] <= new_sum_reg[c];
                        new_sum_reg[c] <= use_sum[c];
                    end
                    old_cnt_reg <= new_cnt_reg;
                    new_cnt_reg <= use_cnt;
                    if (!seen_reg[1])
                    begin
                        seen_reg <= seen_reg + bblur_pkg::SEEN_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int c = 0; c < 3; c++)
            begin
                cur_sum_reg[c] <= live_sum[c];
            end
            cur_cnt_reg <= live_cnt;
            last_reg    <= col_word.last_in_row;
        end
        if (cmd.prep)
        begin
            for (int c = 0; c < 3; c++)
            begin
                num_reg[c] <= win_num[c];
            end
            recip_reg    <= bblur_pkg::recip_of(win_cnt);
            eor_pend_reg <= cmd.job_last;
        end
        if (cmd.fire)
        begin
            for (int c = 0; c < 3; c++)
            begin
                quo_reg[c] <= prod[c][bblur_pkg::RECIP_SHIFT +: bblur_pkg::PIX_W];
            end
            eor_reg <= eor_pend_reg;
        end
    end

    assign status.seen_zero = (seen_reg == '0);
    assign status.last_live = col_word.last_in_row;
    assign status.last_reg  = last_reg;
    assign status.out_free  = !res_valid_reg || res_ready;

    assign res_valid           = res_valid_reg;
    assign res_word.out_red    = quo_reg[0];
    assign res_word.out_green  = quo_reg[1];
    assign res_word.out_blue   = quo_reg[2];
    assign res_word.end_of_row = eor_reg;

endmodule

@@ hdl/bblur_checker.sv @@
module bblur_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [bblur_pkg::PIX_W-1:0] out_red,
    input logic [bblur_pkg::PIX_W-1:0] out_green,
    input logic [bblur_pkg::PIX_W-1:0] out_blue,
    input logic                        out_eor
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red)
            && $stable(out_green) && $stable(out_blue) && $stable(out_eor))
        else $error("stalled result word changed");

    // a busy block stays busy while its result word is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !in_ready |=> !in_ready)
        else $error("column ready rose while the result word stalled");

    // ready only falls because a word was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("column ready dropped without a take");

    // a new result is loaded only while the block is busy with a column
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

endmodule

bind box_blur_edge_aware bblur_checker u_bblur_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (column.valid),
    .in_ready  (column.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_red   (result.out_red),
    .out_green (result.out_green),
    .out_blue  (result.out_blue),
    .out_eor   (result.end_of_row)
);

@@ bench/tb_box_blur_edge_aware.sv @@
`timescale 1ns / 1ps

module tb_box_blur_edge_aware;

    // Hold the result side off long enough that the block backs up into its input.
    localparam int unsigned LONG_HOLD      = 300;
    // Cycles with no word moving on either side before the run is declared hung.
    // The worst correct gap is the long hold above, so this leaves ample margin.
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    // Settle time for the row-closing word and the output register.
    localparam int unsigned SETTLE_CYCLES  = 20;

    // Predicts the blurred pixels the block owes and checks them in order.
    // Keeps its own copy of the two held columns of the current row.
    class blur_predictor;
        logic [bblur_pkg::COL_SUM_W-1:0] held_sum [2][3];  // [0] older, [1] newer; r, g, b
        logic [bblur_pkg::COL_CNT_W-1:0] held_cnt [2];
        logic [bblur_pkg::SEEN_W-1:0]    cols_held;
        bblur_pkg::res_word_t            blurred_due [$];
        int unsigned                     errors;

        function new();
            errors = 0;
            clear_row();
        endfunction

        function void clear_row();
            for (int k = 0; k < 2; k++)
            begin
                held_cnt[k] = '0;
                for (int c = 0; c < 3; c++)
                    held_sum[k][c] = '0;
            end
            cols_held = '0;
        endfunction

        // S/N rounded half up, without fractions.
        function logic [bblur_pkg::PIX_W-1:0] rounded_mean(int unsigned sum, int unsigned cnt);
            return bblur_pkg::PIX_W'((2 * sum + cnt) / (2 * cnt));
        endfunction

        function int unsigned pending();
            return blurred_due.size();
        endfunction

        task report(string msg);
            errors++;
            $display("%0t mismatch %s", $realtime, msg);
        endtask

        // Note an accepted column word: queue the results it releases.
        function void note_column(bblur_pkg::col_word_t w);
            logic [bblur_pkg::PIX_W-1:0] above  [3];
            logic [bblur_pkg::PIX_W-1:0] centre [3];
            logic [bblur_pkg::PIX_W-1:0] below  [3];
            logic [bblur_pkg::PIX_W-1:0] mean   [3];
            int unsigned                 pix_sum [3];
            int unsigned                 pix_cnt;
            int unsigned                 win_sum;
            int unsigned                 win_cnt;
            bblur_pkg::res_word_t        r;
            above  = '{w.top_red, w.top_green, w.top_blue};
            centre = '{w.mid_red, w.mid_green, w.mid_blue};
            below  = '{w.bottom_red, w.bottom_green, w.bottom_blue};
            pix_cnt = 1 + int'(w.has_top) + int'(w.has_bottom);
            for (int c = 0; c < 3; c++)
                pix_sum[c] = int'(centre[c]) + (w.has_top ? int'(above[c]) : 0)
                           + (w.has_bottom ? int'(below[c]) : 0);

            // The newer held column now has its right neighbor.
            if (cols_held >= 1)
            begin
                win_cnt = int'(held_cnt[1]) + pix_cnt;
                if (cols_held >= 2)
                    win_cnt += int'(held_cnt[0]);
                for (int c = 0; c < 3; c++)
                begin
                    win_sum = int'(held_sum[1][c]) + pix_sum[c];
                    if (cols_held >= 2)
                        win_sum += int'(held_sum[0][c]);
                    mean[c] = rounded_mean(win_sum, win_cnt);
                end
                r.out_red    = mean[0];
                r.out_green  = mean[1];
                r.out_blue   = mean[2];
                r.end_of_row = 1'b0;
                blurred_due.push_back(r);
            end

            if (w.last_in_row)
            begin
                // Rightmost pixel: no right neighbor, then drop the row.
                win_cnt = pix_cnt;
                if (cols_held >= 1)
                    win_cnt += int'(held_cnt[1]);
                for (int c = 0; c < 3; c++)
                begin
                    win_sum = pix_sum[c];
                    if (cols_held >= 1)
                        win_sum += int'(held_sum[1][c]);
                    mean[c] = rounded_mean(win_sum, win_cnt);
                end
                r.out_red    = mean[0];
                r.out_green  = mean[1];
                r.out_blue   = mean[2];
                r.end_of_row = 1'b1;
                blurred_due.push_back(r);
                clear_row();
            end
            else
            begin
                for (int c = 0; c < 3; c++)
                begin
                    held_sum[0][c] = held_sum[1][c];
                    held_sum[1][c] = bblur_pkg::COL_SUM_W'(pix_sum[c]);
                end
                held_cnt[0] = held_cnt[1];
                held_cnt[1] = bblur_pkg::COL_CNT_W'(pix_cnt);
                if (cols_held < 2)
                    cols_held++;
            end
        endfunction

        // Check one accepted result word against the oldest expectation.
        task check_pixel(bblur_pkg::res_word_t got);
            bblur_pkg::res_word_t want;
            if (blurred_due.size() == 0)
            begin
                report($sformatf("result word with none expected (%0d %0d %0d eor %0d)",
                                 got.out_red, got.out_green, got.out_blue, got.end_of_row));
                return;
            end
            want = blurred_due.pop_front();
            if (got.out_red !== want.out_red)
                report($sformatf("out_red: expected %0d, got %0d",
                                 want.out_red, got.out_red));
            if (got.out_green !== want.out_green)
                report($sformatf("out_green: expected %0d, got %0d",
                                 want.out_green, got.out_green));
            if (got.out_blue !== want.out_blue)
                report($sformatf("out_blue: expected %0d, got %0d",
                                 want.out_blue, got.out_blue));
            if (got.end_of_row !== want.end_of_row)
                report($sformatf("end_of_row: expected %0d, got %0d",
                                 want.end_of_row, got.end_of_row));
        endtask
    endclass

    logic clk;
    logic rst_n;

    bblur_column_if column_bus ();
    bblur_result_if result_bus ();

    box_blur_edge_aware DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .column (column_bus),
        .result (result_bus)
    );

    blur_predictor blur = new();

    bit          tx_idle_on;     // allow random gaps between column words
    bit          rx_idle_on;     // allow random stalls on the result side
    bit          long_hold_req;  // ask the result side for one long hold-off
    int unsigned fed_items;
    int unsigned idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Build a column word from packed 24-bit RGB triples.
    function automatic bblur_pkg::col_word_t column_of(logic [23:0] above,
                                                       logic [23:0] centre,
                                                       logic [23:0] below,
                                                       bit t, bit b, bit last);
        return bblur_pkg::col_word_t'({above, centre, below, t, b, last});
    endfunction

    // Mostly random colors, with a fair share of black and white.
    function automatic logic [23:0] random_rgb();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return v[23:0];
        endcase
    endfunction

    // Offer one column word, optionally after a random gap, and hold it until taken.
    task automatic send_column(input bblur_pkg::col_word_t w);
        int unsigned gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            column_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        column_bus.valid        <= 1'b1;
        column_bus.top_red      <= w.top_red;
        column_bus.top_green    <= w.top_green;
        column_bus.top_blue     <= w.top_blue;
        column_bus.mid_red      <= w.mid_red;
        column_bus.mid_green    <= w.mid_green;
        column_bus.mid_blue     <= w.mid_blue;
        column_bus.bottom_red   <= w.bottom_red;
        column_bus.bottom_green <= w.bottom_green;
        column_bus.bottom_blue  <= w.bottom_blue;
        column_bus.has_top      <= w.has_top;
        column_bus.has_bottom   <= w.has_bottom;
        column_bus.last_in_row  <= w.last_in_row;
        do
            @(posedge clk);
        while (!column_bus.ready);
        fed_items++;
        blur.note_column(w);
    endtask

    // Send one whole row. Edge flags usually stay fixed across the row, as in a
    // real image; with vary set each column draws its own.
    task automatic send_row(input int unsigned len, input bit vary);
        bit row_top;
        bit row_bot;
        row_top = $urandom_range(0, 1);
        row_bot = $urandom_range(0, 1);
        for (int unsigned k = 0; k < len; k++)
            send_column(column_of(random_rgb(), random_rgb(), random_rgb(),
                                  vary ? bit'($urandom_range(0, 1)) : row_top,
                                  vary ? bit'($urandom_range(0, 1)) : row_bot,
                                  k == len - 1));
    endtask

    // Random rows until the running word count reaches the target. Short rows
    // dominate so row starts and ends come often; some rows run long.
    task automatic send_random_rows(input int unsigned target);
        int unsigned len;
        while (fed_items < target)
        begin
            if ($urandom_range(0, 3) != 0)
                len = $urandom_range(1, 6);
            else
                len = $urandom_range(7, 16);
            send_row(len, $urandom_range(0, 4) == 0);
        end
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic wait_results_drained();
        @(negedge clk);
        column_bus.valid <= 1'b0;
        while (blur.pending() != 0)
            @(posedge clk);
    endtask

    // Stimulus and end of run.
    initial
    begin
        rst_n                   = 1'b0;
        tx_idle_on              = 1'b1;
        rx_idle_on              = 1'b1;
        long_hold_req           = 1'b0;
        fed_items               = 0;
        column_bus.valid        = 1'b0;
        column_bus.top_red      = '0;
        column_bus.top_green    = '0;
        column_bus.top_blue     = '0;
        column_bus.mid_red      = '0;
        column_bus.mid_green    = '0;
        column_bus.mid_blue     = '0;
        column_bus.bottom_red   = '0;
        column_bus.bottom_green = '0;
        column_bus.bottom_blue  = '0;
        column_bus.has_top      = 1'b0;
        column_bus.has_bottom   = 1'b0;
        column_bus.last_in_row  = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // One-pixel rows: no flags (top and bottom set to white must be ignored),
        // both flags, top only, bottom only.
        send_column(column_of(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, 1'b1));
        send_column(column_of(24'h123456, 24'h808080, 24'hFEDCBA, 1'b1, 1'b1, 1'b1));
        send_column(column_of(24'h0A0B0C, 24'h010203, 24'hFFFFFF, 1'b1, 1'b0, 1'b1));
        send_column(column_of(24'h000000, 24'h7F7F7F, 24'h030201, 1'b0, 1'b1, 1'b1));
        // Full-white row with both neighbors: largest window sums.
        send_column(column_of(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b0));
        send_column(column_of(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b0));
        send_column(column_of(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1));
        // Black single-row image; white above and below must not leak in.
        send_column(column_of(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0, 1'b0));
        send_column(column_of(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0, 1'b0));
        send_column(column_of(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0, 1'b1));
        // Two-pixel row averaging to exactly one half: rounds up.
        send_column(column_of(24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b0, 1'b0));
        send_column(column_of(24'h000000, 24'h010101, 24'h000000, 1'b0, 1'b0, 1'b1));
        // Flags that change from column to column within one row.
        send_column(column_of(24'h102030, 24'h405060, 24'h708090, 1'b1, 1'b0, 1'b0));
        send_column(column_of(24'hA0B0C0, 24'hD0E0F0, 24'h0F1F2F, 1'b0, 1'b1, 1'b0));
        send_column(column_of(24'hFF0000, 24'h00FF00, 24'h0000FF, 1'b1, 1'b1, 1'b0));
        send_column(column_of(24'h55AA55, 24'hAA55AA, 24'h5A5A5A, 1'b0, 1'b0, 1'b1));
        // Five columns: the held-column window reaches its full depth.
        send_column(column_of(24'h555555, 24'h555555, 24'h555555, 1'b1, 1'b1, 1'b0));
        send_column(column_of(24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA, 1'b1, 1'b1, 1'b0));
        send_column(column_of(24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b1, 1'b0));
        send_column(column_of(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b0));
        send_column(column_of(24'h808080, 24'h7F7F7F, 24'h818181, 1'b1, 1'b1, 1'b1));

        send_random_rows(450);

        // Back-pressure: the result side holds off while words keep coming, so the
        // block fills and must stall its input. Keep the sender gap-free here.
        tx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        send_row(40, 1'b0);
        tx_idle_on    = 1'b1;

        // Pause the sender until the block has handed back everything.
        wait_results_drained();

        send_random_rows(780);

        // Closing stretch at full rate on both sides.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random_rows(950);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (blur.errors == 0)
            $display("PASS box_blur_edge_aware");
        else
            $display("FAIL box_blur_edge_aware");
        $finish;
    end

    // Result side: ready toggles at the falling edge, in random stall bursts and
    // random runs of readiness, plus the one long hold-off on request.
    initial
    begin
        result_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            result_bus.ready <= 1'b1;
            repeat ($urandom_range(0, 11)) @(negedge clk);
        end
    end

    // Check each result word at the edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            blur.check_pixel(bblur_pkg::res_word_t'({result_bus.out_red,
                                                     result_bus.out_green,
                                                     result_bus.out_blue,
                                                     result_bus.end_of_row}));
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (column_bus.valid && column_bus.ready)
                   || (result_bus.valid && result_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no word moved for %0d cycles", $realtime, idle_cycles);
            $display("FAIL box_blur_edge_aware");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

@@ files.f @@
hdl/bblur_pkg.sv
hdl/bblur_column_if.sv
hdl/bblur_result_if.sv
hdl/bblur_ctrl.sv
hdl/bblur_dp.sv
hdl/box_blur_edge_aware.sv
hdl/bblur_checker.sv
bench/tb_box_blur_edge_aware.sv
